@@ rtl/core/dtlv_pkg.sv @@
package dtlv_pkg;

  // parse phases
  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN,
    PH_EXT,
    PH_VAL
  } phase_e;

  // result codes
  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_VALUE,
    KIND_END,
    KIND_LEN_ERR
  } res_kind_e;

  // configuration register indexes
  localparam logic CFG_STRIP   = 1'b0;
  localparam logic CFG_DESCEND = 1'b1;

  // result queue depth, room for two full bytes worth of results
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_LVL_W = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    res_kind_e    kind;
    logic [4:0]   tag;
    logic         cons;
    logic [31:0]  vlen;
    logic [32:0]  total;
    logic [7:0]   vbyte;
    logic         last;
  } res_t;

  function automatic res_t mk_res(res_kind_e kind, logic [4:0] tag, logic cons,
                                  logic [31:0] vlen, logic [32:0] total,
                                  logic [7:0] vbyte);
    res_t r;
    r.kind  = kind;
    r.tag   = tag;
    r.cons  = cons;
    r.vlen  = vlen;
    r.total = total;
    r.vbyte = vbyte;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/core/der_tlv_stream_parser.sv @@
// channel | direction | handshake              | payload
// in      | sink      | in_valid_i / in_stall_o   | data_byte_i, restart_i
// out     | source    | out_valid_o / out_stall_i | result_kind_o .. last_o
// cfg     | sink      | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// one input word per cycle unless stalled: a word is held in the input register,
// where the parse step turns it into zero, one or two results
// a word with two results (header or value byte plus end) pushes both at once
// reset clears the parse state, the queue and the registers (strip 0, descend 1)
// an output stall fills the four-entry result queue; the input stalls once the
// held word cannot find room for two results
module der_tlv_stream_parser
  import dtlv_pkg::*;
#(
  parameter int LEN_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [4:0]  tag_number_o,
  output logic        constructed_o,
  output logic [31:0] value_length_o,
  output logic [32:0] field_total_size_o,
  output logic [7:0]  value_byte_o,
  output logic        last_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_wdata_i
);

  // configuration registers
  logic strip_q, strip_d;
  logic descend_q, descend_d;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_restart_q;

  logic                 go;
  logic                 in_acc;
  logic [1:0]           n_res;
  logic [1:0]           push_cnt;
  res_t                 res0, res1, head;
  logic [RES_LVL_W-1:0] level;
  logic                 pop;

  always_comb begin
    strip_d   = strip_q;
    descend_d = descend_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STRIP:   strip_d   = cfg_wdata_i;
        CFG_DESCEND: descend_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // held word proceeds when the queue can take both possible results
  assign go         = in_valid_q && (level <= RES_LVL_W'(RES_DEPTH - 2));
  assign in_stall_o = in_valid_q && !go;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_valid_d = in_acc ? 1'b1 : (go ? 1'b0 : in_valid_q);
  assign push_cnt   = go ? n_res : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q    <= 1'b0;
      descend_q  <= 1'b1;
      in_valid_q <= 1'b0;
    end else begin
      strip_q    <= strip_d;
      descend_q  <= descend_d;
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q    <= data_byte_i;
      in_restart_q <= restart_i;
    end
  end

  dtlv_parse_core #(
    .LEN_BYTES(LEN_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .data_byte_i (in_byte_q),
    .restart_i   (in_restart_q),
    .strip_i     (strip_q),
    .descend_i   (descend_q),
    .n_res_o     (n_res),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  dtlv_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .wdata0_i   (res0),
    .wdata1_i   (res1),
    .pop_i      (pop),
    .rdata_o    (head),
    .level_o    (level)
  );

  assign out_valid_o        = (level != '0);
  assign pop                = out_valid_o && !out_stall_i;
  assign result_kind_o      = head.kind;
  assign tag_number_o       = head.tag;
  assign constructed_o      = head.cons;
  assign value_length_o     = head.vlen;
  assign field_total_size_o = head.total;
  assign value_byte_o       = head.vbyte;
  assign last_o             = head.last;

  // queue never overfills
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= RES_LVL_W'(RES_DEPTH))
    else $error("result queue level beyond depth");

  // a held word that cannot go is kept for the next cycle
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !go |=> in_valid_q)
    else $error("held input word dropped");

  // last marks only the final result of a word
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && n_res == 2'd1 |-> res0.last)
    else $error("single result without last");

  a_last_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && n_res == 2'd2 |-> res1.last && !res0.last)
    else $error("result pair with wrong last marks");

endmodule

@@ rtl/core/dtlv_parse_core.sv @@
module dtlv_parse_core
  import dtlv_pkg::*;
#(
  parameter int LEN_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       go_i,
  input  logic [7:0] data_byte_i,
  input  logic       restart_i,
  input  logic       strip_i,
  input  logic       descend_i,
  output logic [1:0] n_res_o,
  output res_t       res0_o,
  output res_t       res1_o
);

  localparam int LfbW = $clog2(LEN_BYTES + 1);

  phase_e           phase_q, phase_d, ph;
  logic [4:0]       tag_q, tag_d;
  logic             cons_q, cons_d;
  logic [LfbW-1:0]  lbl_q, lbl_d;
  logic [LfbW-1:0]  lfb_q, lfb_d;
  logic [31:0]      acc_q, acc_d;
  logic [31:0]      vbl_q, vbl_d;
  logic             zip_q, zip_d;
  logic [31:0]      slen_q, slen_d;
  logic [32:0]      total_q, total_d;

  logic             ld;
  logic             skip;
  logic [31:0]      acc_n;
  logic [LfbW-1:0]  lfb_n;
  logic [32:0]      tot_n;
  logic [31:0]      slen_dec;

  assign ph       = restart_i ? PH_TAG : phase_q;
  assign slen_dec = slen_q - 32'd1;
  assign skip     = zip_q && (data_byte_i == 8'h00);

  always_comb begin
    phase_d = phase_q;
    tag_d   = tag_q;
    cons_d  = cons_q;
    lbl_d   = lbl_q;
    lfb_d   = lfb_q;
    acc_d   = acc_q;
    vbl_d   = vbl_q;
    zip_d   = zip_q;
    slen_d  = slen_q;
    total_d = total_q;
    ld      = 1'b0;
    acc_n   = acc_q;
    lfb_n   = lfb_q;
    tot_n   = '0;
    n_res_o = 2'd0;
    res0_o  = '0;
    res1_o  = '0;
    if (go_i) begin
      unique case (ph)
        PH_TAG: begin
          tag_d   = data_byte_i[4:0];
          cons_d  = data_byte_i[5];
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (!data_byte_i[7]) begin
            ld    = 1'b1;
            acc_n = {24'd0, data_byte_i};
            lfb_n = '0;
          end else if (data_byte_i[6:0] == 7'd0 || data_byte_i[6:0] > 7'(LEN_BYTES)) begin
            res0_o  = mk_res(KIND_LEN_ERR, tag_q, cons_q, '0, '0, '0);
            n_res_o = 2'd1;
            phase_d = PH_TAG;
          end else begin
            lfb_d   = LfbW'(data_byte_i[6:0]);
            lbl_d   = LfbW'(data_byte_i[6:0]);
            acc_d   = '0;
            phase_d = PH_EXT;
          end
        end
        PH_EXT: begin
          if (acc_q[31:24] != 8'd0) begin
            res0_o  = mk_res(KIND_LEN_ERR, tag_q, cons_q, '0, '0, '0);
            n_res_o = 2'd1;
            phase_d = PH_TAG;
          end else begin
            acc_n = {acc_q[23:0], data_byte_i};
            acc_d = acc_n;
            lbl_d = lbl_q - LfbW'(1);
            if (lbl_q == LfbW'(1)) begin
              ld = 1'b1;
            end
          end
        end
        PH_VAL: begin
          vbl_d = vbl_q - 32'd1;
          if (skip) begin
            slen_d = slen_dec;
          end else begin
            zip_d   = 1'b0;
            res0_o  = mk_res(KIND_VALUE, tag_q, cons_q, '0, '0, data_byte_i);
            n_res_o = 2'd1;
          end
          if (vbl_q == 32'd1) begin
            phase_d = PH_TAG;
            if (skip) begin
              res0_o  = mk_res(KIND_END, tag_q, cons_q, slen_dec, total_q, '0);
              n_res_o = 2'd1;
            end else begin
              res1_o  = mk_res(KIND_END, tag_q, cons_q, slen_q, total_q, '0);
              n_res_o = 2'd2;
            end
          end
        end
        default: ;
      endcase

      // length complete: header, then value, end or descend
      if (ld) begin
        tot_n   = {1'b0, acc_n} + 33'(lfb_n) + 33'd2;
        acc_d   = acc_n;
        lfb_d   = lfb_n;
        res0_o  = mk_res(KIND_HEADER, tag_q, cons_q, acc_n, tot_n, '0);
        n_res_o = 2'd1;
        if (cons_q && descend_i) begin
          phase_d = PH_TAG;
        end else if (acc_n == 32'd0) begin
          res1_o  = mk_res(KIND_END, tag_q, cons_q, '0, tot_n, '0);
          n_res_o = 2'd2;
          phase_d = PH_TAG;
        end else begin
          vbl_d   = acc_n;
          slen_d  = acc_n;
          total_d = tot_n;
          zip_d   = (lfb_n == '0) ? (strip_i && acc_n > 32'd1) : strip_i;
          phase_d = PH_VAL;
        end
      end

      if (n_res_o == 2'd1) begin
        res0_o.last = 1'b1;
      end else if (n_res_o == 2'd2) begin
        res1_o.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      tag_q   <= '0;
      cons_q  <= 1'b0;
      lbl_q   <= '0;
      lfb_q   <= '0;
      acc_q   <= '0;
      vbl_q   <= '0;
      zip_q   <= 1'b0;
      slen_q  <= '0;
      total_q <= '0;
    end else begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      cons_q  <= cons_d;
      lbl_q   <= lbl_d;
      lfb_q   <= lfb_d;
      acc_q   <= acc_d;
      vbl_q   <= vbl_d;
      zip_q   <= zip_d;
      slen_q  <= slen_d;
      total_q <= total_d;
    end
  end

endmodule

@@ rtl/core/dtlv_res_fifo.sv @@
module dtlv_res_fifo
  import dtlv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_cnt_i,
  input  res_t                 wdata0_i,
  input  res_t                 wdata1_i,
  input  logic                 pop_i,
  output res_t                 rdata_o,
  output logic [RES_LVL_W-1:0] level_o
);

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_LVL_W-1:0] level_q, level_d;

  assign rdata_o  = mem_q[rd_ptr_q];
  assign level_o  = level_q;
  assign wr_ptr_d = wr_ptr_q + RES_PTR_W'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + RES_PTR_W'(pop_i);
  assign level_d  = level_q + RES_LVL_W'(push_cnt_i) - RES_LVL_W'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wdata0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + RES_PTR_W'(1)] <= wdata1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

endmodule
